// ===== design/hashed_lifo_stack_unit_assert.svh =====
// Assertion macros shared by the hashed LIFO stack RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef HASHED_LIFO_STACK_UNIT_ASSERT_SVH
`define HASHED_LIFO_STACK_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define HLS_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hashed_lifo_stack: assertion failed");

`define HLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hashed_lifo_stack: assertion failed");

`define HLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hashed_lifo_stack: assertion failed");

`else

`define HLS_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define HLS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/hls_pkg.sv =====
// Shared types, constants and the hash multiply for the hashed LIFO stack.
// No dependencies; imported by every module of the block.
package hls_pkg;

  localparam int unsigned HASH_W = 64;

  localparam logic [HASH_W-1:0] SEED_RESET = 64'h0000_0000_1603_2007;
  localparam logic [HASH_W-1:0] HASH_MULT  = 64'h0000_0000_0100_0193;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_HASH,
    ST_POP_LOAD,
    ST_WALK_READ,
    ST_WALK_LOAD,
    ST_WALK_HASH,
    ST_DONE
  } hls_state_t;

  // Enables from the sequencer to the storage.
  typedef struct packed {
    logic ent_we;
    logic pre_we;
    logic rd_en;
  } hls_mem_ctl_t;

  // Multiply by HASH_MULT modulo 2^64. The prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1,
  // so the product is a sum of six shifted copies.
  function automatic logic [HASH_W-1:0] hash_mul(input logic [HASH_W-1:0] h);
    return h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
  endfunction

endpackage

// ===== design/hls_hash_unit.sv =====
// Shared bit-serial hash unit: folds one data bit per cycle into the hash.
// Depends on hls_pkg and the assertion macro header.
`include "hashed_lifo_stack_unit_assert.svh"

module hls_hash_unit
  import hls_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [HASH_W-1:0]     h0,
  input  logic [DATA_WIDTH-1:0] word,
  output logic                  done,
  output logic [HASH_W-1:0]     hash
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [HASH_W-1:0]     h_r;
  logic [DATA_WIDTH-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Bits are taken from the LSB upward: xor the bit in, then multiply.
  always_ff @(posedge clk) begin
    if (start) begin
      h_r    <= h0;
      word_r <= word;
    end else if (busy_r) begin
      h_r    <= hash_mul(h_r ^ {{(HASH_W-1){1'b0}}, word_r[0]});
      word_r <= word_r >> 1;
    end
  end

  assign done = done_r;
  assign hash = h_r;

  `HLS_ASSERT_IMPL(a_start_idle, clk, rst_n, start, !busy_r)
  `HLS_ASSERT_IMPL(a_done_idle, clk, rst_n, done_r, !busy_r && !start)

endmodule

// ===== design/hls_store.sv =====
// Entry memory and per-level prefix hash memory of the stack.
// Uses hls_pkg; one write port each, a shared read address, registered reads.
module hls_store
  import hls_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  hls_mem_ctl_t             mem_ctl,
  input  logic [$clog2(DEPTH)-1:0] ent_waddr,
  input  logic [DATA_WIDTH-1:0]    ent_wdata,
  input  logic [$clog2(DEPTH)-1:0] pre_waddr,
  input  logic [HASH_W-1:0]        pre_wdata,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]    ent_rdata,
  output logic [HASH_W-1:0]        pre_rdata
);

  logic [DATA_WIDTH-1:0] ent_mem [DEPTH];
  logic [HASH_W-1:0]     pre_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (mem_ctl.rd_en) begin
      ent_rdata <= ent_mem[rd_addr];
    end
  end

  // Entry k holds the hash after entries 0..k under the current seed.
  always_ff @(posedge clk) begin
    if (mem_ctl.pre_we) begin
      pre_mem[pre_waddr] <= pre_wdata;
    end
    if (mem_ctl.rd_en) begin
      pre_rdata <= pre_mem[rd_addr];
    end
  end

endmodule

// ===== design/hls_seq.sv =====
// Sequencer of the hashed LIFO stack: stack pointer, seed, sticky flags and walks.
// Depends on hls_pkg, the assertion macro header, and drives hls_store and hls_hash_unit.
`include "hashed_lifo_stack_unit_assert.svh"

module hls_seq
  import hls_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic signed [DATA_WIDTH-1:0]    in_value,
  input  logic                            cfg_we,
  input  logic [HASH_W-1:0]               cfg_data,
  output logic                            hu_start,
  output logic [HASH_W-1:0]               hu_h0,
  output logic [DATA_WIDTH-1:0]           hu_word,
  input  logic                            hu_done,
  input  logic [HASH_W-1:0]               hu_hash,
  output hls_mem_ctl_t                    mem_ctl,
  output logic [$clog2(DEPTH)-1:0]        ent_waddr,
  output logic [DATA_WIDTH-1:0]           ent_wdata,
  output logic [$clog2(DEPTH)-1:0]        pre_waddr,
  output logic [HASH_W-1:0]               pre_wdata,
  output logic [$clog2(DEPTH)-1:0]        rd_addr,
  input  logic [DATA_WIDTH-1:0]           ent_rdata,
  input  logic [HASH_W-1:0]               pre_rdata,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic signed [DATA_WIDTH-1:0]    res_top,
  output logic [$clog2(DEPTH+1)-1:0]      res_count,
  output logic [HASH_W-1:0]               res_hash,
  output logic                            res_ovf,
  output logic                            res_unf
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  hls_state_t                   state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [HASH_W-1:0]            seed_r, seed_nxt;
  logic [HASH_W-1:0]            hash_r, hash_nxt;
  logic signed [DATA_WIDTH-1:0] top_r, top_nxt;
  logic                         dirty_r, dirty_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         unf_r, unf_nxt;
  logic                         is_full;
  logic                         is_empty;
  logic [CW-1:0]                count_new;
  logic [CW-1:0]                count_dec;
  logic [CW-1:0]                idx_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      seed_r  <= SEED_RESET;
      hash_r  <= SEED_RESET;
      top_r   <= '0;
      dirty_r <= 1'b0;
      ovf_r   <= 1'b0;
      unf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      seed_r  <= seed_nxt;
      hash_r  <= hash_nxt;
      top_r   <= top_nxt;
      dirty_r <= dirty_nxt;
      ovf_r   <= ovf_nxt;
      unf_r   <= unf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign count_dec = count_r - 1'b1;
  assign idx_inc   = idx_r + 1'b1;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    seed_nxt  = seed_r;
    hash_nxt  = hash_r;
    top_nxt   = top_r;
    dirty_nxt = dirty_r;
    ovf_nxt   = ovf_r;
    unf_nxt   = unf_r;
    count_new = count_r;
    hu_start  = 1'b0;
    hu_h0     = hash_r;
    hu_word   = in_value;
    mem_ctl   = '0;
    ent_waddr = count_r[AW-1:0];
    ent_wdata = in_value;
    pre_waddr = count_dec[AW-1:0];
    pre_wdata = hu_hash;
    rd_addr   = count_r[AW-1:0] - 2'd2;
    res_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_PUSH) begin
            if (!is_full) begin
              mem_ctl.ent_we = 1'b1;
              count_new      = count_r + 1'b1;
              top_nxt        = in_value;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (!is_empty) begin
              count_new = count_dec;
            end else begin
              unf_nxt = 1'b1;
            end
          end
          count_nxt = count_new;

          if (dirty_r) begin
            // The seed changed since the prefixes were built: rebuild them all.
            idx_nxt  = '0;
            hash_nxt = seed_r;
            top_nxt  = '0;
            if (count_new == '0) begin
              dirty_nxt = 1'b0;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_WALK_READ;
            end
          end else if (in_cmd == CMD_PUSH) begin
            if (!is_full) begin
              hu_start  = 1'b1;
              state_nxt = ST_PUSH_HASH;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            if (count_new == '0) begin
              hash_nxt  = seed_r;
              top_nxt   = '0;
              state_nxt = ST_DONE;
            end else begin
              // The new top sits at index count-2 before the pop.
              mem_ctl.rd_en = 1'b1;
              state_nxt     = ST_POP_LOAD;
            end
          end
        end
      end

      ST_PUSH_HASH: begin
        if (hu_done) begin
          mem_ctl.pre_we = 1'b1;
          hash_nxt       = hu_hash;
          state_nxt      = ST_DONE;
        end
      end

      ST_POP_LOAD: begin
        top_nxt   = ent_rdata;
        hash_nxt  = pre_rdata;
        state_nxt = ST_DONE;
      end

      ST_WALK_READ: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = idx_r[AW-1:0];
        state_nxt     = ST_WALK_LOAD;
      end

      ST_WALK_LOAD: begin
        hu_start  = 1'b1;
        hu_word   = ent_rdata;
        top_nxt   = ent_rdata;
        state_nxt = ST_WALK_HASH;
      end

      ST_WALK_HASH: begin
        if (hu_done) begin
          mem_ctl.pre_we = 1'b1;
          pre_waddr      = idx_r[AW-1:0];
          hash_nxt       = hu_hash;
          idx_nxt        = idx_inc;
          if (idx_inc == count_r) begin
            dirty_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WALK_READ;
          end
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // User must make seed writes only in idle (unchecked); they mark prefix hashes stale.
    if (cfg_we) begin
      seed_nxt  = cfg_data;
      dirty_nxt = 1'b1;
    end
  end

  assign res_top   = top_r;
  assign res_count = count_r;
  assign res_hash  = hash_r;
  assign res_ovf   = ovf_r;
  assign res_unf   = unf_r;

  `HLS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `HLS_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_r, ovf_r)
  `HLS_ASSERT_NEXT(a_unf_sticky, clk, rst_n, unf_r, unf_r)

endmodule

// ===== design/hashed_lifo_stack_unit.sv =====
// Hashed LIFO stack: push/pop requests, each answered with top, fill count and content hash.
// A push hashes the value in the bit-serial hash unit; a pop that leaves entries loads the
// new top and its stored prefix hash. After a seed write the next request instead rebuilds
// all prefix hashes. A new request is taken only once the last result has moved to the
// output register. Synchronous reset (rst_n low) empties the stack, clears both sticky
// flags and loads seed 0x16032007; memories are not cleared.
`include "hashed_lifo_stack_unit_assert.svh"

module hashed_lifo_stack_unit
  import hls_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // in_tdata: value
  input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]       in_tdata,
  // in_tuser: cmd (0 push, 1 pop)
  input  logic                                          in_tuser,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // out_tdata: top_value, fill_count, content_hash, overflow_seen, underflow_seen
  output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + HASH_W + 2 + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  input  logic                                          cfg_wr_en,
  input  logic [HASH_W-1:0]                             cfg_wr_data
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int OUT_W  = DATA_WIDTH + CW + HASH_W + 2;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // Storage traffic between the sequencer and the two memories.
  hls_mem_ctl_t                 mem_ctl;
  logic [AW-1:0]                ent_waddr;
  logic [DATA_WIDTH-1:0]        ent_wdata;
  logic [AW-1:0]                pre_waddr;
  logic [HASH_W-1:0]            pre_wdata;
  logic [AW-1:0]                rd_addr;
  logic [DATA_WIDTH-1:0]        ent_rdata;
  logic [HASH_W-1:0]            pre_rdata;

  // Shared hash unit hookup.
  logic                         hu_start;
  logic [HASH_W-1:0]            hu_h0;
  logic [DATA_WIDTH-1:0]        hu_word;
  logic                         hu_done;
  logic [HASH_W-1:0]            hu_hash;

  // Finished result, held by the sequencer until the output register takes it.
  logic                         res_valid;
  logic                         res_ready;
  logic signed [DATA_WIDTH-1:0] res_top;
  logic [CW-1:0]                res_count;
  logic [HASH_W-1:0]            res_hash;
  logic                         res_ovf;
  logic                         res_unf;

  logic                         out_valid_r;
  logic [OUT_TW-1:0]            out_data_r;

  hls_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_value  (in_tdata[DATA_WIDTH-1:0]),
    .cfg_we    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .hu_start  (hu_start),
    .hu_h0     (hu_h0),
    .hu_word   (hu_word),
    .hu_done   (hu_done),
    .hu_hash   (hu_hash),
    .mem_ctl   (mem_ctl),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .pre_waddr (pre_waddr),
    .pre_wdata (pre_wdata),
    .rd_addr   (rd_addr),
    .ent_rdata (ent_rdata),
    .pre_rdata (pre_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_top   (res_top),
    .res_count (res_count),
    .res_hash  (res_hash),
    .res_ovf   (res_ovf),
    .res_unf   (res_unf)
  );

  hls_hash_unit #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hu_start),
    .h0    (hu_h0),
    .word  (hu_word),
    .done  (hu_done),
    .hash  (hu_hash)
  );

  hls_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .pre_waddr (pre_waddr),
    .pre_wdata (pre_wdata),
    .rd_addr   (rd_addr),
    .ent_rdata (ent_rdata),
    .pre_rdata (pre_rdata)
  );

  // The output register frees the sequencer as soon as a result is copied out,
  // so the next request can be taken while this one waits on out_tready.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Fields packed from the lowest bit up, zero padded to whole bytes.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= OUT_TW'({res_unf, res_ovf, res_hash, res_count, res_top});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A result is only presented while the sequencer refuses new requests.
  `HLS_ASSERT_IMPL(a_res_blocks_input, clk, rst_n, res_valid, !in_tready)

endmodule
